// File: rtl/lfba_pkg.sv
package lfba_pkg;

   localparam int NUM_BLOCKS_DEF = 4096;
   localparam int MAX_RUN_DEF = 512;
   localparam int QUEUE_DEPTH = 2;

   localparam int ADDR_W = 48;
   localparam int SHIFT_W = 5;
   localparam int BLOCK_W = 12;
   localparam int COUNT_W = 13;
   localparam int CMD_W = 2;
   localparam int RUN_W = 10;
   localparam int FRAME_W = 36;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_BLOCK = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd3;

   localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RESET = 5'd12;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 2'd0,
      ST_SHORT = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_INIT,
      OP_ALLOC,
      OP_RELEASE,
      OP_REJECT
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [RUN_W-1:0] run_length;
      logic [FRAME_W-1:0] release_frame;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [ADDR_W-1:0] block_address;
      logic [COUNT_W-1:0] free_blocks;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] region_base;
      logic [SHIFT_W-1:0] block_shift;
      logic [BLOCK_W-1:0] first_block;
      logic [COUNT_W-1:0] block_count;
   } cfg_type;

   typedef struct packed {
      op_type op;
      logic [RUN_W-1:0] run;
   } job_ctl_type;

endpackage

// File: rtl/lfba_ram.sv
module lfba_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/lfba_queue.sv
module lfba_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign empty = (count_ff == '0);
   assign do_push = push && (count_ff < CW'(DEPTH));
   assign do_pop = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/lfba_front.sv
module lfba_front import lfba_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int MAX_RUN = MAX_RUN_DEF,
   localparam int IDX_W = $clog2(NUM_BLOCKS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_type           req,
   input  cfg_type           cfg,
   output logic              push,
   output job_ctl_type       job,
   output logic [IDX_W-1:0]  job_idx
);

   localparam int SHL_W = FRAME_W + 2 ** SHIFT_W - 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int SUM_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

   logic a_valid_ff;
   logic [CMD_W-1:0] a_cmd_ff;
   logic [RUN_W-1:0] a_run_ff;
   logic [ADDR_W-1:0] a_byte_ff;
   logic a_ovf_ff;

   logic [SHL_W-1:0] wide;
   logic [ADDR_W:0] diff;
   logic [ADDR_W-1:0] idx_full;
   logic [SUM_W-1:0] init_end;
   logic in_region, run_ok;

   assign wide = SHL_W'(req.release_frame) << cfg.block_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff <= req.cmd;
         a_run_ff <= req.run_length;
         a_byte_ff <= wide[ADDR_W-1:0];
         a_ovf_ff <= |wide[SHL_W-1:ADDR_W];
      end
   end

   assign diff = {1'b0, a_byte_ff} - {1'b0, cfg.region_base};
   assign idx_full = diff[ADDR_W-1:0] >> cfg.block_shift;
   assign in_region = !a_ovf_ff && !diff[ADDR_W] && (idx_full < ADDR_W'(NUM_BLOCKS));
   assign init_end = SUM_W'(cfg.first_block) + SUM_W'(cfg.block_count);
   assign run_ok = (a_run_ff != '0) && (SUM_W'(a_run_ff) <= SUM_W'(MAX_RUN));

   always_comb begin
      job.run = a_run_ff;
      case (a_cmd_ff)
         CMD_INIT: begin
            job.op = (init_end > SUM_W'(NUM_BLOCKS)) ? OP_REJECT : OP_INIT;
         end
         CMD_ALLOC: begin
            job.op = run_ok ? OP_ALLOC : OP_REJECT;
         end
         CMD_RELEASE: begin
            job.op = in_region ? OP_RELEASE : OP_REJECT;
         end
         default: begin
            job.op = OP_REJECT;
         end
      endcase
   end

   assign job_idx = idx_full[IDX_W-1:0];
   assign push = a_valid_ff;

endmodule

// File: rtl/lfba_back.sv
module lfba_back import lfba_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   localparam int IDX_W = $clog2(NUM_BLOCKS),
   localparam int PTR_W = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_empty,
   input  job_ctl_type       q_job,
   input  logic [IDX_W-1:0]  q_idx,
   output logic              q_pop,
   output logic              ram_we,
   output logic [IDX_W-1:0]  ram_waddr,
   output logic [PTR_W-1:0]  ram_wdata,
   output logic [IDX_W-1:0]  ram_raddr,
   input  logic [PTR_W-1:0]  ram_rdata,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int SUM_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
   localparam int CMP_W = PTR_W + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INIT,
      S_WALK
   } state_type;

   state_type state_ff;
   logic [PTR_W-1:0] head_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] init_pos_ff;
   logic [COUNT_W-1:0] init_left_ff;
   logic [RUN_W-1:0] run_ff, remain_ff;
   logic cur_ok_ff;
   logic [ADDR_W-1:0] off_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [CNT_W-1:0] init_next;
   logic [PTR_W-1:0] init_link, walk_next;
   logic [CNT_W-1:0] count_left;
   logic head_ok, list_full;

   assign init_next = init_pos_ff + 1'b1;
   assign init_link = (init_next < CNT_W'(NUM_BLOCKS)) ? PTR_W'(init_next) : '0;
   assign walk_next = (!cur_ok_ff || (CMP_W'(ram_rdata) >= CMP_W'(NUM_BLOCKS))) ?
                      '0 : ram_rdata;
   assign count_left = count_ff - CNT_W'(run_ff);
   assign head_ok = CMP_W'(head_ff) < CMP_W'(NUM_BLOCKS);
   assign list_full = count_ff >= CNT_W'(NUM_BLOCKS);
   assign q_pop = (state_ff == S_IDLE) && !q_empty;

   always_comb begin
      ram_we = 1'b0;
      ram_waddr = init_pos_ff[IDX_W-1:0];
      ram_wdata = init_link;
      ram_raddr = head_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (!q_empty && (q_job.op == OP_RELEASE) && !list_full) begin
               ram_we = 1'b1;
               ram_waddr = q_idx;
               ram_wdata = head_ff;
            end
         end
         S_INIT: begin
            ram_we = 1'b1;
         end
         S_WALK: begin
            ram_raddr = walk_next[IDX_W-1:0];
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  rsp_data_ff.block_address <= '0;
                  rsp_data_ff.free_blocks <= COUNT_W'(count_ff);
                  case (q_job.op)
                     OP_INIT: begin
                        if (cfg.block_count == '0) begin
                           head_ff <= PTR_W'(cfg.first_block);
                           count_ff <= '0;
                           rsp_data_ff.status <= ST_OK;
                           rsp_data_ff.free_blocks <= '0;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           init_pos_ff <= CNT_W'(cfg.first_block);
                           init_left_ff <= cfg.block_count;
                           state_ff <= S_INIT;
                        end
                     end
                     OP_ALLOC: begin
                        if (SUM_W'(count_ff) < SUM_W'(q_job.run)) begin
                           rsp_data_ff.status <= ST_SHORT;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           run_ff <= q_job.run;
                           remain_ff <= q_job.run;
                           cur_ok_ff <= head_ok;
                           off_ff <= ADDR_W'(head_ff) << cfg.block_shift;
                           state_ff <= S_WALK;
                        end
                     end
                     OP_RELEASE: begin
                        if (list_full) begin
                           rsp_data_ff.status <= ST_RANGE;
                        end else begin
                           head_ff <= PTR_W'(q_idx);
                           count_ff <= count_ff + 1'b1;
                           rsp_data_ff.status <= ST_OK;
                           rsp_data_ff.free_blocks <= COUNT_W'(count_ff + 1'b1);
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     default: begin
                        rsp_data_ff.status <= ST_RANGE;
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_INIT: begin
               init_pos_ff <= init_next;
               init_left_ff <= init_left_ff - 1'b1;
               if (init_left_ff == COUNT_W'(1)) begin
                  head_ff <= PTR_W'(cfg.first_block);
                  count_ff <= CNT_W'(cfg.block_count);
                  rsp_data_ff.status <= ST_OK;
                  rsp_data_ff.block_address <= '0;
                  rsp_data_ff.free_blocks <= cfg.block_count;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_WALK: begin
               remain_ff <= remain_ff - 1'b1;
               cur_ok_ff <= 1'b1;
               if (remain_ff == RUN_W'(1)) begin
                  head_ff <= walk_next;
                  count_ff <= count_left;
                  rsp_data_ff.status <= ST_OK;
                  rsp_data_ff.block_address <= cfg.region_base + off_ff;
                  rsp_data_ff.free_blocks <= COUNT_W'(count_left);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: rtl/linked_free_block_allocator.sv
// An accepted command is registered in the front stage, queued, and executed by the back end.
// Release, rejected commands, short allocates and empty inits answer from the idle state;
// allocate makes one link memory read per block popped, and init one link memory write per
// block linked. A new command is accepted at the edge that takes the result beat, so
// commands never overlap. Results are strobed for one cycle and cannot be stalled.
// Synchronous reset empties the list and loads the register defaults; links are not cleared.
module linked_free_block_allocator import lfba_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int MAX_RUN = MAX_RUN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  req_type                req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int PTR_W = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W;
   localparam int JOB_W = $bits(job_ctl_type) + IDX_W;

   cfg_type cfg_ff;
   logic busy_ff, busy_in;
   logic accept;

   logic push, pop, q_empty;
   job_ctl_type f_job, q_job;
   logic [IDX_W-1:0] f_idx, q_idx;
   logic [JOB_W-1:0] q_out;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [PTR_W-1:0] ram_wdata, ram_rdata;

   assign busy = busy_ff && !rsp_valid;
   assign accept = start && !busy;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (rsp_valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cfg_ff.region_base <= '0;
         cfg_ff.block_shift <= BLOCK_SHIFT_RESET;
         cfg_ff.first_block <= '0;
         cfg_ff.block_count <= '0;
      end else begin
         busy_ff <= busy_in;
         if (csr_we) begin
            case (csr_index)
               CSR_REGION_BASE: cfg_ff.region_base <= csr_wdata[ADDR_W-1:0];
               CSR_BLOCK_SHIFT: cfg_ff.block_shift <= csr_wdata[SHIFT_W-1:0];
               CSR_FIRST_BLOCK: cfg_ff.first_block <= csr_wdata[BLOCK_W-1:0];
               CSR_BLOCK_COUNT: cfg_ff.block_count <= csr_wdata[COUNT_W-1:0];
               default: cfg_ff <= cfg_ff;
            endcase
         end
      end
   end

   lfba_front #(
      .NUM_BLOCKS(NUM_BLOCKS),
      .MAX_RUN(MAX_RUN)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .cfg(cfg_ff),
      .push(push),
      .job(f_job),
      .job_idx(f_idx)
   );

   lfba_queue #(
      .WIDTH(JOB_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data({f_job, f_idx}),
      .pop(pop),
      .pop_data(q_out),
      .empty(q_empty)
   );

   assign q_job = q_out[JOB_W-1:IDX_W];
   assign q_idx = q_out[IDX_W-1:0];

   lfba_back #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(q_empty),
      .q_job(q_job),
      .q_idx(q_idx),
      .q_pop(pop),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   lfba_ram #(
      .WIDTH(PTR_W),
      .DEPTH(NUM_BLOCKS)
   ) u_link_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

endmodule

// File: rtl/lfba_checker.sv
module lfba_checker import lfba_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Every beat is a single-cycle strobe.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted command");

   a_result_needs_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a command in flight");

   a_failed_address_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.block_address == '0))
      else $error("failed command returned a block address");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.free_blocks) <= NUM_BLOCKS))
      else $error("free count above the number of blocks");

endmodule

bind linked_free_block_allocator lfba_checker #(
   .NUM_BLOCKS(NUM_BLOCKS)
) u_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);

// File: tb/lfba_checker.sv
`timescale 1ns / 1ps

module tb_lfba_checker import lfba_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   cfg_type            layout;
   logic [BLOCK_W-1:0] next_link [NUM_BLOCKS_DEF];
   logic [BLOCK_W-1:0] head_block;
   logic [COUNT_W-1:0] free_total;
   rsp_type            free_list_results_q [$];
   rsp_type            want;

   function automatic rsp_type run_free_list_command(req_type r);
      rsp_type     res;
      logic [63:0] word;
      logic [63:0] slot;
      int          i;
      int          succ;
      res.status = ST_OK;
      res.block_address = '0;
      case (r.cmd)
         CMD_INIT: begin
            if (int'(layout.first_block) + int'(layout.block_count) > NUM_BLOCKS_DEF) begin
               res.status = ST_RANGE;
            end else begin
               for (i = 0; i < int'(layout.block_count); i++) begin
                  succ = int'(layout.first_block) + i + 1;
                  next_link[int'(layout.first_block) + i] =
                     (succ < NUM_BLOCKS_DEF) ? BLOCK_W'(succ) : '0;
               end
               head_block = layout.first_block;
               free_total = layout.block_count;
            end
         end
         CMD_ALLOC: begin
            if (r.run_length == 0 || int'(r.run_length) > MAX_RUN_DEF) begin
               res.status = ST_RANGE;
            end else if (int'(free_total) < int'(r.run_length)) begin
               res.status = ST_SHORT;
            end else begin
               word = {16'd0, layout.region_base} + (64'(head_block) << layout.block_shift);
               res.block_address = word[ADDR_W-1:0];
               for (i = 0; i < int'(r.run_length); i++) begin
                  head_block = next_link[head_block];
               end
               free_total = free_total - COUNT_W'(r.run_length);
            end
         end
         CMD_RELEASE: begin
            word = 64'(r.release_frame);
            if ((word >> (ADDR_W - int'(layout.block_shift))) != 0) begin
               res.status = ST_RANGE;
            end else begin
               word = word << layout.block_shift;
               if (word < {16'd0, layout.region_base}) begin
                  res.status = ST_RANGE;
               end else begin
                  slot = (word - {16'd0, layout.region_base}) >> layout.block_shift;
                  if (slot >= NUM_BLOCKS_DEF || int'(free_total) >= NUM_BLOCKS_DEF) begin
                     res.status = ST_RANGE;
                  end else begin
                     next_link[slot[BLOCK_W-1:0]] = head_block;
                     head_block = slot[BLOCK_W-1:0];
                     free_total = free_total + 1'b1;
                  end
               end
            end
         end
         default: begin
            res.status = ST_RANGE;
         end
      endcase
      res.free_blocks = free_total;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         layout.region_base = '0;
         layout.block_shift = BLOCK_SHIFT_RESET;
         layout.first_block = '0;
         layout.block_count = '0;
         head_block = '0;
         free_total = '0;
         free_list_results_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REGION_BASE: layout.region_base = csr_wdata[ADDR_W-1:0];
               CSR_BLOCK_SHIFT: layout.block_shift = csr_wdata[SHIFT_W-1:0];
               CSR_FIRST_BLOCK: layout.first_block = csr_wdata[BLOCK_W-1:0];
               CSR_BLOCK_COUNT: layout.block_count = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         // The result of one command and the acceptance of the next share an edge,
         // so the result beat is checked before the new prediction is queued.
         if (rsp_valid) begin
            if (free_list_results_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result beat: status %0d address %h free %0d",
                           rsp_data.status, rsp_data.block_address, rsp_data.free_blocks);
               end
               fail_count++;
            end else begin
               want = free_list_results_q.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.block_address !== want.block_address ||
                   rsp_data.free_blocks !== want.free_blocks) begin
                  if (fail_count < 10) begin
                     $display("result mismatch: status %0d/%0d address %h/%h free %0d/%0d",
                              want.status, rsp_data.status, want.block_address,
                              rsp_data.block_address, want.free_blocks,
                              rsp_data.free_blocks);
                  end
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            free_list_results_q.push_back(run_free_list_command(req_data));
         end
      end
      pending = free_list_results_q.size();
   end

endmodule

// File: tb/tb_linked_free_block_allocator.sv
`timescale 1ns / 1ps

module tb_linked_free_block_allocator import lfba_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_ILLEGAL = 2'd3;
   localparam int CYCLE_LIMIT = 20_000_000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   req_type                req_data;
   logic                   busy;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending;
   int                     free_est;
   int                     cycle_count = 0;
   cfg_type                cur_cfg;
   int                     gap_plan [8] = '{0, 51, 11, 51, 0, 11, 51, 0};

   linked_free_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tb_lfba_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         free_est <= 0;
      end else if (rsp_valid) begin
         free_est <= int'(rsp_data.free_blocks);
      end
   end

   function automatic req_type make_req(logic [CMD_W-1:0] c, logic [RUN_W-1:0] run,
                                        logic [FRAME_W-1:0] frame);
      req_type r;
      r.cmd = c;
      r.run_length = run;
      r.release_frame = frame;
      return r;
   endfunction

   function automatic cfg_type random_layout();
      cfg_type c;
      int      room;
      case ($urandom_range(3))
         0: c.region_base = '0;
         1: c.region_base = ADDR_W'({$urandom, $urandom});
         2: c.region_base = {ADDR_W{1'b1}};
         default: c.region_base = ADDR_W'($urandom_range(0, 1 << 20));
      endcase
      c.block_shift = SHIFT_W'($urandom_range(9, 16));
      c.first_block = ($urandom_range(3) == 0) ? BLOCK_W'($urandom_range(4095))
                                               : BLOCK_W'($urandom_range(64));
      room = NUM_BLOCKS_DEF - int'(c.first_block);
      if ($urandom_range(9) == 0) begin
         c.block_count = COUNT_W'($urandom_range(NUM_BLOCKS_DEF));
      end else begin
         c.block_count = COUNT_W'(room - $urandom_range(0, (room > 32) ? 32 : room));
      end
      return c;
   endfunction

   // Releases mostly land inside the region, so that allocations walk links
   // that earlier releases rewrote.
   function automatic req_type next_random_req();
      int                 pick;
      int                 ceiling;
      logic [63:0]        frame_lo;
      logic [63:0]        frame;
      logic [RUN_W-1:0]   run;
      pick = $urandom_range(99);
      ceiling = (free_est < 1) ? 1 : ((free_est > MAX_RUN_DEF) ? MAX_RUN_DEF : free_est);
      frame_lo = ({16'd0, cur_cfg.region_base} + (64'd1 << cur_cfg.block_shift) - 64'd1)
                 >> cur_cfg.block_shift;
      if (pick < 2) begin
         return make_req(CMD_INIT, RUN_W'($urandom), FRAME_W'({$urandom, $urandom}));
      end
      if (pick < 4) begin
         return make_req(CMD_ILLEGAL, RUN_W'($urandom), FRAME_W'({$urandom, $urandom}));
      end
      if (pick < ((free_est > 16) ? 55 : 25)) begin
         case ($urandom_range(19))
            0: run = RUN_W'($urandom);
            1: run = RUN_W'(free_est + 1);
            2, 3, 4, 5: run = RUN_W'($urandom_range(1, ceiling));
            default: run = RUN_W'($urandom_range(1, 8));
         endcase
         return make_req(CMD_ALLOC, run, FRAME_W'({$urandom, $urandom}));
      end
      case ($urandom_range(9))
         0: frame = {$urandom, $urandom};
         1: frame = frame_lo - 64'd1;
         2: frame = frame_lo + NUM_BLOCKS_DEF;
         default: frame = frame_lo + $urandom_range(NUM_BLOCKS_DEF - 1);
      endcase
      return make_req(CMD_RELEASE, RUN_W'($urandom), FRAME_W'(frame));
   endfunction

   task automatic issue(req_type r, int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   task automatic load_config(cfg_type c);
      logic [CSR_DATA_W-1:0] value [4];
      int                    i;
      wait_idle();
      value[CSR_REGION_BASE] = CSR_DATA_W'(c.region_base);
      value[CSR_BLOCK_SHIFT] = CSR_DATA_W'(c.block_shift);
      value[CSR_FIRST_BLOCK] = CSR_DATA_W'(c.first_block);
      value[CSR_BLOCK_COUNT] = CSR_DATA_W'(c.block_count);
      for (i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_cfg = c;
   endtask

   initial begin
      int phase;
      int n;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cur_cfg = cfg_type'{48'd0, BLOCK_SHIFT_RESET, 12'd0, 13'd0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Every link is written by the full init below before any allocation can
      // walk the list.
      issue(make_req(CMD_ALLOC, 10'd1, 36'd0), 0);
      issue(make_req(CMD_ILLEGAL, 10'h3FF, 36'hF_FFFF_FFFF), 0);
      issue(make_req(CMD_INIT, 10'd0, 36'd0), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'd0), 0);

      load_config(cfg_type'{48'd0, 5'd12, 12'd0, 13'd4096});
      issue(make_req(CMD_INIT, 10'd0, 36'd0), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'd5), 0);
      issue(make_req(CMD_ALLOC, 10'd0, 36'd0), 0);
      issue(make_req(CMD_ALLOC, 10'd513, 36'd0), 0);
      issue(make_req(CMD_ALLOC, 10'h3FF, 36'd0), 0);
      issue(make_req(CMD_ALLOC, 10'd512, 36'd0), 0);
      issue(make_req(CMD_ALLOC, 10'd1, 36'd0), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'd4095), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'd4096), 0);
      issue(make_req(CMD_ALLOC, 10'd1, 36'd0), 0);

      load_config(cfg_type'{48'hFFFF_FFF0_0000, 5'd16, 12'd4000, 13'd96});
      issue(make_req(CMD_INIT, 10'd0, 36'd0), 0);
      issue(make_req(CMD_ALLOC, 10'd64, 36'd0), 0);
      issue(make_req(CMD_ALLOC, 10'd33, 36'd0), 0);
      issue(make_req(CMD_ALLOC, 10'd32, 36'd0), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'h0_FFFF_FFF0), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'h0_FFFF_FFEF), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'hF_FFFF_FFFF), 0);

      load_config(cfg_type'{48'd1, 5'd9, 12'd4095, 13'd2});
      issue(make_req(CMD_INIT, 10'd0, 36'd0), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'd0), 0);
      issue(make_req(CMD_RELEASE, 10'd0, 36'd1), 0);

      for (phase = 0; phase < 8; phase++) begin
         load_config(random_layout());
         issue(make_req(CMD_INIT, RUN_W'($urandom), FRAME_W'({$urandom, $urandom})),
               gap_plan[phase]);
         for (n = 0; n < 185; n++) begin
            issue(next_random_req(), gap_plan[phase]);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
